// ----- design/sar_rx_pkg.sv -----
// Shared types and codes for the segmented-transfer receiver.
// No dependencies; imported by every sar_rx module and the top level.
`timescale 1ns / 1ps

package sar_rx_pkg;

    // Command codes carried with each input beat
    typedef enum logic [2:0] {
        CMD_OPEN   = 3'd0,
        CMD_PACKET = 3'd1,
        CMD_READY  = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_CLOSE  = 3'd4
    } cmd_t;

    // Status codes returned with each result beat
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_BUSY    = 3'd2,
        ST_IO      = 3'd3,
        ST_DECODE  = 3'd4,
        ST_SINK    = 3'd5,
        ST_START   = 3'd6
    } status_t;

    // Control state, one-hot
    typedef enum logic [4:0] {
        CS_IDLE   = 5'b00001,
        CS_READY  = 5'b00010,
        CS_ACTIVE = 5'b00100,
        CS_ENDED  = 5'b01000,
        CS_FAILED = 5'b10000
    } ctrl_state_t;

    // Encoded state as reported on the result bus
    localparam logic [2:0] CODE_IDLE   = 3'd0;
    localparam logic [2:0] CODE_READY  = 3'd1;
    localparam logic [2:0] CODE_ACTIVE = 3'd2;
    localparam logic [2:0] CODE_ENDED  = 3'd3;
    localparam logic [2:0] CODE_FAILED = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic       decode_ok;
        logic       flag_fin;
        logic       flag_idle;
        logic       flag_first;
        logic       flag_last;
        logic [7:0] pkt_seq;
        logic [7:0] payload_len;
        logic       sink_error;
        logic       start_error;
    } rx_item_t;

    typedef struct packed {
        status_t    status;
        logic       deliver;
        logic       ack_valid;
        logic       ack_nack;
        logic [7:0] ack_seq;
        logic [7:0] ack_window;
        logic       end_valid;
        logic       end_success;
        logic [2:0] rx_state;
    } rx_result_t;

    function automatic logic [2:0] state_code(ctrl_state_t st);
        logic [2:0] code;
        unique case (st)
            CS_IDLE:   code = CODE_IDLE;
            CS_READY:  code = CODE_READY;
            CS_ACTIVE: code = CODE_ACTIVE;
            CS_ENDED:  code = CODE_ENDED;
            CS_FAILED: code = CODE_FAILED;
            default:   code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- design/sar_transfer_receiver.sv -----
// Top level of the segmented-transfer receiver: stream ports, window register, stages.
// Depends on sar_rx_pkg, sar_rx_in_reg, sar_rx_core and sar_rx_out_reg.
`timescale 1ns / 1ps

// Segmented-transfer receiver. Each slave beat is one command (open, packet,
// ready, timer tick, close, carried in s_tuser) and produces exactly one master
// beat with status, delivery, acknowledgement and end-of-transfer information.
// Throughput is one beat per clock while m_tready does not stall the output.
// An accepted beat sits in the input register; its result is then loaded into
// the result register, which drives m_tvalid, once that register is empty or
// its held beat leaves. The rate is set by the update of the control state,
// the last in-order sequence number and the ack-armed flag in the decision
// stage, which every beat reads and writes. The window register is written
// through cfg_valid/cfg_data and must only change while no beat is in flight;
// cfg_ready is always high.
module sar_transfer_receiver #(
    parameter int SEQ_BITS     = 8,
    parameter int WINDOW_LIMIT = 255
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // window

    input  logic        s_tvalid,
    output logic        s_tready,
    // decode_ok, flag_fin, flag_idle, flag_first, pkt_seq[7:0],
    // payload_len[7:0], sink_error, start_error, zero pad
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,      // cmd
    input  logic        s_tlast,      // flag_last

    output logic        m_tvalid,
    input  logic        m_tready,
    // deliver, ack_valid, ack_nack, ack_seq[7:0], ack_window[7:0],
    // end_success, rx_state[2:0], zero pad
    output logic [23:0] m_tdata,
    output logic [2:0]  m_tuser,      // status
    output logic        m_tlast       // end_valid
);
    import sar_rx_pkg::*;

    logic       [7:0] window_reg;
    rx_item_t         in_item;
    rx_item_t         item;
    logic             item_valid;
    logic             advance;
    rx_result_t       result;
    rx_result_t       result_out;

    // Window register: always ready, hold between writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            window_reg <= cfg_data;
        end
    end

    // Unpack the slave beat
    always_comb
    begin
        in_item.cmd         = s_tuser;
        in_item.decode_ok   = s_tdata[0];
        in_item.flag_fin    = s_tdata[1];
        in_item.flag_idle   = s_tdata[2];
        in_item.flag_first  = s_tdata[3];
        in_item.flag_last   = s_tlast;
        in_item.pkt_seq     = s_tdata[11:4];
        in_item.payload_len = s_tdata[19:12];
        in_item.sink_error  = s_tdata[20];
        in_item.start_error = s_tdata[21];
    end

    sar_rx_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sar_rx_core #(
        .SEQ_BITS     (SEQ_BITS),
        .WINDOW_LIMIT (WINDOW_LIMIT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .window  (window_reg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    sar_rx_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result_in  (result),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result_out (result_out)
    );

    // Pack the master beat
    assign m_tdata = {1'b0,
                      result_out.rx_state,
                      result_out.end_success,
                      result_out.ack_window,
                      result_out.ack_seq,
                      result_out.ack_nack,
                      result_out.ack_valid,
                      result_out.deliver};
    assign m_tuser = result_out.status;
    assign m_tlast = result_out.end_valid;

endmodule

// ----- design/sar_rx_in_reg.sv -----
// Input register stage: holds one accepted beat until the decision stage takes it.
// Depends on sar_rx_pkg.
`timescale 1ns / 1ps

module sar_rx_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sar_rx_pkg::rx_item_t in_item,
    input  logic                advance,
    output logic                item_valid,
    output sar_rx_pkg::rx_item_t item
);
    import sar_rx_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;

    // Free when empty or when the held beat moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- design/sar_rx_core.sv -----
// Decision stage: control state, last in-order sequence and ack arming.
// Depends on sar_rx_pkg.
`timescale 1ns / 1ps

module sar_rx_core #(
    parameter int SEQ_BITS     = 8,
    parameter int WINDOW_LIMIT = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            window,
    input  sar_rx_pkg::rx_item_t  item,
    input  logic                  advance,
    output sar_rx_pkg::rx_result_t result
);
    import sar_rx_pkg::*;

    localparam logic [SEQ_BITS-1:0] SeqMax = {SEQ_BITS{1'b1}};
    localparam logic [7:0] WinLimit = 8'(WINDOW_LIMIT);

    ctrl_state_t         state_reg;
    ctrl_state_t         state_next;
    logic [SEQ_BITS-1:0] last_seq_reg;
    logic [SEQ_BITS-1:0] last_seq_next;
    logic                armed_reg;
    logic                armed_next;

    logic [SEQ_BITS-1:0] seq_m;
    logic [SEQ_BITS-1:0] seq_expect;
    logic [7:0]          last_low;
    status_t             status;
    logic                deliver;
    logic                send;
    logic                end_valid;
    logic                end_success;
    logic                in_order;

    // Fit the 8-bit packet sequence into SEQ_BITS, and the stored sequence into 8 bits
    for (genvar i = 0; i < SEQ_BITS; i++)
    begin : g_seq_in
        if (i < 8)
        begin : g_bit
            assign seq_m[i] = item.pkt_seq[i];
        end
        else
        begin : g_zero
            assign seq_m[i] = 1'b0;
        end
    end

    for (genvar j = 0; j < 8; j++)
    begin : g_seq_out
        if (j < SEQ_BITS)
        begin : g_bit
            assign last_low[j] = last_seq_next[j];
        end
        else
        begin : g_zero
            assign last_low[j] = 1'b0;
        end
    end

    assign seq_expect = last_seq_reg + SEQ_BITS'(1);
    assign in_order   = (seq_m == seq_expect);

    always_comb
    begin
        state_next    = state_reg;
        last_seq_next = last_seq_reg;
        armed_next    = armed_reg;
        status        = ST_OK;
        deliver       = 1'b0;
        send          = 1'b0;
        end_valid     = 1'b0;
        end_success   = 1'b0;

        unique case (item.cmd)
            CMD_OPEN:
            begin
                if (window > WinLimit)
                begin
                    status = ST_INVALID;
                end
                else if (state_reg != CS_IDLE && state_reg != CS_FAILED)
                begin
                    status = ST_BUSY;
                end
                else
                begin
                    last_seq_next = SeqMax;
                    if (item.start_error)
                    begin
                        state_next = CS_IDLE;
                        armed_next = 1'b0;
                        status     = ST_START;
                    end
                    else
                    begin
                        state_next = CS_READY;
                        armed_next = 1'b1;
                        send       = 1'b1;
                    end
                end
            end
            CMD_PACKET:
            begin
                priority if (!item.decode_ok)
                begin
                    state_next = CS_FAILED;
                    end_valid  = 1'b1;
                    status     = ST_DECODE;
                end
                else if (item.flag_fin)
                begin
                    priority if (item.payload_len != 8'd0)
                    begin
                        state_next = CS_FAILED;
                        end_valid  = 1'b1;
                        status     = ST_INVALID;
                    end
                    else if (state_reg == CS_IDLE || state_reg == CS_FAILED)
                    begin
                        status = ST_INVALID;
                    end
                    else if (state_reg != CS_ENDED)
                    begin
                        state_next = CS_FAILED;
                        end_valid  = 1'b1;
                        status     = ST_INVALID;
                    end
                    else
                    begin
                        // FIN with the idle flag closes the transfer cleanly
                        state_next  = item.flag_idle ? CS_IDLE : CS_FAILED;
                        end_valid   = 1'b1;
                        end_success = item.flag_idle;
                    end
                end
                else if (item.flag_first && state_reg != CS_READY)
                begin
                    state_next = CS_FAILED;
                    end_valid  = 1'b1;
                    status     = ST_IO;
                end
                else if (!item.flag_first && state_reg != CS_ACTIVE)
                begin
                    state_next = CS_FAILED;
                    end_valid  = 1'b1;
                    status     = ST_BUSY;
                end
                else
                begin
                    state_next = item.flag_last ? CS_ENDED : CS_ACTIVE;
                    armed_next = 1'b1;
                    send       = 1'b1;
                    // Out-of-order packets are dropped but still acknowledged
                    if (in_order)
                    begin
                        if (item.payload_len != 8'd0 && item.sink_error)
                        begin
                            deliver    = 1'b1;
                            state_next = CS_FAILED;
                            end_valid  = 1'b1;
                            status     = ST_SINK;
                        end
                        else
                        begin
                            deliver       = (item.payload_len != 8'd0);
                            last_seq_next = seq_m;
                        end
                    end
                end
            end
            CMD_READY:
            begin
                armed_next = 1'b1;
                send       = 1'b1;
            end
            CMD_TICK:
            begin
                send = armed_reg;
            end
            CMD_CLOSE:
            begin
                armed_next = 1'b0;
                if (state_reg == CS_ACTIVE || state_reg == CS_READY)
                begin
                    state_next = CS_FAILED;
                    end_valid  = 1'b1;
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        result.status      = status;
        result.deliver     = deliver;
        result.ack_valid   = send;
        result.ack_nack    = send && (state_next == CS_FAILED);
        result.ack_seq     = send ? last_low : 8'd0;
        result.ack_window  = send ? window : 8'd0;
        result.end_valid   = end_valid;
        result.end_success = end_success;
        result.rx_state    = state_code(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CS_IDLE;
            last_seq_reg <= SeqMax;
            armed_reg    <= 1'b0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            last_seq_reg <= last_seq_next;
            armed_reg    <= armed_next;
        end
    end

    a_end_leaves_open: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.end_valid |=> state_reg == CS_IDLE || state_reg == CS_FAILED)
        else $error("transfer end left the control in an open state");

    a_open_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.cmd == CMD_OPEN && result.status == ST_OK
        |=> last_seq_reg == SeqMax && armed_reg && state_reg == CS_READY)
        else $error("open did not restart sequence and arm the ack");

    a_close_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.cmd == CMD_CLOSE |=> !armed_reg)
        else $error("close left the ack armed");

    a_sink_fails: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.status == ST_SINK
        |=> state_reg == CS_FAILED && last_seq_reg == $past(last_seq_reg))
        else $error("sink rejection must fail without advancing the sequence");

endmodule

// ----- design/sar_rx_out_reg.sv -----
// Result register stage: holds one result beat until the consumer takes it.
// Depends on sar_rx_pkg.
`timescale 1ns / 1ps

module sar_rx_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  sar_rx_pkg::rx_result_t result_in,
    output logic                   advance,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sar_rx_pkg::rx_result_t result_out
);
    import sar_rx_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rx_result_t result_reg;

    // Take a new result when empty or when the held one leaves this cycle
    assign advance    = item_valid && (!valid_reg || out_ready);
    assign valid_next = advance ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ----- sim/sar_rx_checker.sv -----
// Scoreboard for the segmented-transfer receiver: watches the config, slave and master channels.
// Predicts each result beat from its own copy of the control state; depends on sar_rx_pkg.
`timescale 1ns / 1ps

module sar_rx_checker
    import sar_rx_pkg::*;
#(
    parameter int WINDOW_LIMIT = 255
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,

    output int          mismatches,
    output int          pending,
    output int          results_checked,
    output int          deliveries,
    output int          transfer_ends,
    output int          nacks
);

    // Shadow of the receiver state
    logic [2:0] rx_mode;
    logic [7:0] seq_in_order;
    logic       ack_armed;
    logic [7:0] window_reg;
    logic       ended_now;
    logic       ended_ok;

    rx_result_t awaited_results[$];

    function automatic void end_transfer(input logic ok);
        ended_now = 1'b1;
        ended_ok  = ok;
        rx_mode   = ok ? CODE_IDLE : CODE_FAILED;
    endfunction

    function automatic status_t packet_outcome(input rx_item_t b, output logic dlv,
                                               output logic snd);
        logic [7:0] next_seq;
        dlv = 1'b0;
        snd = 1'b0;
        next_seq = seq_in_order + 8'd1;
        if (!b.decode_ok)
        begin
            end_transfer(1'b0);
            return ST_DECODE;
        end
        if (b.flag_fin)
        begin
            if (b.payload_len != 8'd0)
            begin
                end_transfer(1'b0);
                return ST_INVALID;
            end
            if (rx_mode == CODE_IDLE || rx_mode == CODE_FAILED)
                return ST_INVALID;
            if (rx_mode != CODE_ENDED)
            begin
                end_transfer(1'b0);
                return ST_INVALID;
            end
            end_transfer(b.flag_idle);
            return ST_OK;
        end
        if (b.flag_first)
        begin
            if (rx_mode != CODE_READY)
            begin
                end_transfer(1'b0);
                return ST_IO;
            end
            rx_mode = CODE_ACTIVE;
        end
        else if (rx_mode != CODE_ACTIVE)
        begin
            end_transfer(1'b0);
            return ST_BUSY;
        end
        if (b.flag_last)
            rx_mode = CODE_ENDED;
        ack_armed = 1'b1;
        snd = 1'b1;
        // out of order: ignore, ack still goes out
        if (b.pkt_seq != next_seq)
            return ST_OK;
        if (b.payload_len != 8'd0)
        begin
            dlv = 1'b1;
            if (b.sink_error)
            begin
                end_transfer(1'b0);
                return ST_SINK;
            end
        end
        seq_in_order = b.pkt_seq;
        return ST_OK;
    endfunction

    function automatic rx_result_t next_result(input rx_item_t b);
        rx_result_t r;
        status_t    st;
        logic       dlv;
        logic       snd;
        st = ST_OK;
        dlv = 1'b0;
        snd = 1'b0;
        ended_now = 1'b0;
        ended_ok = 1'b0;
        case (b.cmd)
            CMD_OPEN:
                if (window_reg > WINDOW_LIMIT)
                    st = ST_INVALID;
                else if (rx_mode != CODE_IDLE && rx_mode != CODE_FAILED)
                    st = ST_BUSY;
                else
                begin
                    seq_in_order = 8'hFF;
                    if (b.start_error)
                    begin
                        rx_mode = CODE_IDLE;
                        ack_armed = 1'b0;
                        st = ST_START;
                    end
                    else
                    begin
                        rx_mode = CODE_READY;
                        ack_armed = 1'b1;
                        snd = 1'b1;
                    end
                end
            CMD_PACKET:
                st = packet_outcome(b, dlv, snd);
            CMD_READY:
            begin
                ack_armed = 1'b1;
                snd = 1'b1;
            end
            CMD_TICK:
                snd = ack_armed;
            CMD_CLOSE:
            begin
                ack_armed = 1'b0;
                if (rx_mode == CODE_ACTIVE || rx_mode == CODE_READY)
                    end_transfer(1'b0);
            end
            default:
                st = ST_INVALID;
        endcase
        r.status      = st;
        r.deliver     = dlv;
        r.ack_valid   = snd;
        r.ack_nack    = snd && (rx_mode == CODE_FAILED);
        r.ack_seq     = snd ? seq_in_order : 8'd0;
        r.ack_window  = snd ? window_reg : 8'd0;
        r.end_valid   = ended_now;
        r.end_success = ended_now && ended_ok;
        r.rx_state    = rx_mode;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rx_item_t   beat_in;
        rx_result_t want;
        rx_result_t got;
        if (!rst_n)
        begin
            rx_mode = CODE_IDLE;
            seq_in_order = 8'hFF;
            ack_armed = 1'b0;
            window_reg = 8'd0;
            awaited_results.delete();
            mismatches = 0;
            pending = 0;
            results_checked = 0;
            deliveries = 0;
            transfer_ends = 0;
            nacks = 0;
        end
        else
        begin
            // Retire the oldest expectation on each result beat
            if (m_tvalid && m_tready)
            begin
                got.status      = status_t'(m_tuser);
                got.deliver     = m_tdata[0];
                got.ack_valid   = m_tdata[1];
                got.ack_nack    = m_tdata[2];
                got.ack_seq     = m_tdata[10:3];
                got.ack_window  = m_tdata[18:11];
                got.end_success = m_tdata[19];
                got.rx_state    = m_tdata[22:20];
                got.end_valid   = m_tlast;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected, actual %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("deliver", want.deliver, got.deliver);
                    check_field("ack_valid", want.ack_valid, got.ack_valid);
                    check_field("ack_nack", want.ack_nack, got.ack_nack);
                    check_field("ack_seq", want.ack_seq, got.ack_seq);
                    check_field("ack_window", want.ack_window, got.ack_window);
                    check_field("end_valid", want.end_valid, got.end_valid);
                    check_field("end_success", want.end_success, got.end_success);
                    check_field("rx_state", want.rx_state, got.rx_state);
                    results_checked++;
                end
                if (got.deliver)
                    deliveries++;
                if (got.end_valid)
                    transfer_ends++;
                if (got.ack_valid && got.ack_nack)
                    nacks++;
            end

            if (cfg_valid && cfg_ready)
                window_reg = cfg_data;

            if (s_tvalid && s_tready)
            begin
                beat_in.cmd         = s_tuser;
                beat_in.decode_ok   = s_tdata[0];
                beat_in.flag_fin    = s_tdata[1];
                beat_in.flag_idle   = s_tdata[2];
                beat_in.flag_first  = s_tdata[3];
                beat_in.pkt_seq     = s_tdata[11:4];
                beat_in.payload_len = s_tdata[19:12];
                beat_in.sink_error  = s_tdata[20];
                beat_in.start_error = s_tdata[21];
                beat_in.flag_last   = s_tlast;
                awaited_results.push_back(next_result(beat_in));
            end

            pending = awaited_results.size();
        end
    end

endmodule

// ----- sim/tb_sar_transfer_receiver.sv -----
// Top of the segmented-transfer receiver testbench: clock, reset, stimulus and verdict.
// Depends on sar_rx_pkg, sar_transfer_receiver and sar_rx_checker.
`timescale 1ns / 1ps

module tb_sar_transfer_receiver;

    import sar_rx_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    wire         cfg_ready;

    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = 24'd0;
    logic [2:0]  s_tuser = 3'd0;
    logic        s_tlast = 1'b0;
    wire         s_tready;

    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;

    int mismatches;
    int pending;
    int results_checked;
    int deliveries;
    int transfer_ends;
    int nacks;

    int beats_sent = 0;
    int settings_used = 0;
    int stall_left = 0;
    bit send_gaps = 1'b0;
    bit recv_stalls = 1'b0;

    // 2 ns clock
    always #1 clk = ~clk;

    sar_transfer_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    sar_rx_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .deliveries      (deliveries),
        .transfer_ends   (transfer_ends),
        .nacks           (nacks)
    );

    // Receiver back-pressure: stall in random bursts while enabled,
    // otherwise hold m_tready high.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (recv_stalls && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic rx_item_t cmd_item(input logic [2:0] c, input logic start_err);
        rx_item_t b;
        b = '0;
        b.cmd = c;
        b.start_error = start_err;
        return b;
    endfunction

    function automatic rx_item_t pkt_item(input logic ok, input logic fin, input logic idle,
                                          input logic first, input logic last,
                                          input logic [7:0] seq, input logic [7:0] plen,
                                          input logic serr);
        rx_item_t b;
        b = '0;
        b.cmd         = CMD_PACKET;
        b.decode_ok   = ok;
        b.flag_fin    = fin;
        b.flag_idle   = idle;
        b.flag_first  = first;
        b.flag_last   = last;
        b.pkt_seq     = seq;
        b.payload_len = plen;
        b.sink_error  = serr;
        return b;
    endfunction

    // Present one beat on the slave side and hold it until accepted. Entered and
    // left at a falling edge; a random gap may come first.
    task automatic push_beat(input rx_item_t b);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.cmd;
        s_tlast  <= b.flag_last;
        s_tdata  <= {2'b00, b.start_error, b.sink_error, b.payload_len, b.pkt_seq,
                     b.flag_first, b.flag_idle, b.flag_fin, b.decode_ok};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result beat has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write the window register with nothing in flight.
    task automatic set_window(input logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One transfer: open, a run of data packets, then FIN, close or nothing.
    // A broken transfer flips flags, spoils decode and injects sink errors.
    task automatic run_transfer(input bit broken);
        rx_item_t   b;
        int         n;
        int         k;
        int         ending;
        logic [7:0] seq;
        logic [7:0] plen;
        push_beat(cmd_item(CMD_OPEN, $urandom_range(0, 24) == 0));
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (k = 0; k < n; k++)
        begin
            // interleave ack requests and timer ticks
            if ($urandom_range(0, 6) == 0)
                push_beat(cmd_item($urandom_range(0, 1) ? CMD_READY : CMD_TICK, 1'b0));
            seq = k[7:0];
            if ($urandom_range(0, 11) == 0)
                seq = 8'($urandom_range(0, 255));
            plen = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            b = pkt_item(1'b1, 1'b0, 1'($urandom_range(0, 1)), k == 0, k == n - 1, seq,
                         plen, $urandom_range(0, 49) == 0);
            if (broken)
            begin
                if ($urandom_range(0, 9) == 0)
                    b.decode_ok = 1'b0;
                if ($urandom_range(0, 7) == 0)
                    b.flag_first = ~b.flag_first;
                if ($urandom_range(0, 7) == 0)
                    b.flag_last = ~b.flag_last;
                if ($urandom_range(0, 11) == 0)
                    b.flag_fin = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    b.sink_error = 1'b1;
            end
            push_beat(b);
        end
        ending = $urandom_range(0, 9);
        if (ending < 8)
        begin
            plen = (broken && $urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            push_beat(pkt_item(1'b1, 1'b1, $urandom_range(0, 6) != 0, 1'b0, 1'b0,
                               8'($urandom_range(0, 255)), plen, 1'b0));
        end
        else if (ending == 8)
            push_beat(cmd_item(CMD_CLOSE, 1'b0));
        // otherwise leave the transfer hanging; unless it failed, the next open sees busy
    endtask

    initial
    begin : stimulus
        int          phase;
        int          phase_end;
        int          pick;
        int          k;
        logic [25:0] noise;
        logic [7:0]  win;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_gaps = 1'b1;
        recv_stalls = 1'b1;

        // Directed: every command, the corner cases of the control
        push_beat(cmd_item(CMD_TICK, 1'b0));                   // tick while not armed
        push_beat(pkt_item(1, 1, 1, 0, 0, 8'd0, 8'd0, 0));     // FIN in idle
        push_beat(pkt_item(1, 0, 0, 0, 0, 8'd0, 8'd0, 0));     // data in idle, fails
        push_beat(cmd_item(3'd5, 1'b0));                       // unknown commands
        push_beat(cmd_item(3'd7, 1'b0));
        push_beat(cmd_item(CMD_CLOSE, 1'b0));                  // close in failed
        push_beat(cmd_item(CMD_OPEN, 1'b1));                   // start failure
        set_window(8'h5A);
        push_beat(cmd_item(CMD_OPEN, 1'b0));                   // good open
        push_beat(cmd_item(CMD_OPEN, 1'b0));                   // open while busy
        push_beat(pkt_item(1, 0, 0, 1, 0, 8'd0, 8'hFF, 0));    // first, full payload
        push_beat(pkt_item(1, 0, 0, 0, 0, 8'd5, 8'd3, 0));     // out of order
        push_beat(pkt_item(1, 0, 0, 0, 0, 8'd1, 8'd0, 0));     // in order, no payload
        push_beat(pkt_item(1, 0, 0, 1, 0, 8'd2, 8'd1, 0));     // FIRST while active
        push_beat(cmd_item(CMD_OPEN, 1'b0));                   // reopen from failed
        push_beat(cmd_item(CMD_READY, 1'b0));
        push_beat(cmd_item(CMD_TICK, 1'b0));                   // tick while armed
        push_beat(pkt_item(1, 0, 0, 1, 1, 8'd0, 8'd0, 0));     // first and last at once
        push_beat(pkt_item(1, 1, 1, 0, 0, 8'hFF, 8'd0, 0));    // clean FIN
        push_beat(cmd_item(CMD_OPEN, 1'b0));
        push_beat(pkt_item(1, 0, 0, 1, 0, 8'd0, 8'd9, 1));     // sink rejects
        push_beat(pkt_item(0, 0, 0, 0, 0, 8'd1, 8'd0, 0));     // decode failure
        push_beat(cmd_item(CMD_OPEN, 1'b0));
        push_beat(cmd_item(CMD_CLOSE, 1'b0));                  // close from ready
        push_beat(cmd_item(CMD_OPEN, 1'b0));
        push_beat(pkt_item(1, 1, 1, 0, 0, 8'd0, 8'd0, 0));     // FIN while ready

        // Random phases, one window setting each; the last runs without idling
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       win = 8'h00;
                2:       win = 8'hFF;
                4:       win = 8'h01;
                default: win = 8'($urandom_range(0, 255));
            endcase
            if (phase == 5)
            begin
                send_gaps = 1'b0;
                recv_stalls = 1'b0;
            end
            set_window(win);
            phase_end = beats_sent + 240;
            while (beats_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    drain();
                else if (pick < 75)
                    run_transfer(1'b0);
                else if (pick < 90)
                    run_transfer(1'b1);
                else
                begin
                    // raw noise, every field random
                    for (k = $urandom_range(1, 4); k > 0; k--)
                    begin
                        noise = 26'($urandom);
                        push_beat(rx_item_t'(noise));
                    end
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d beats over %0d window settings: %0d deliveries,",
                 beats_sent, settings_used, deliveries);
        $display("%0d transfer ends and %0d nacks among %0d checked results.",
                 transfer_ends, nacks, results_checked);
        if (mismatches == 0 && pending == 0)
            $display("tb_sar_transfer_receiver: clean");
        else
            $display("tb_sar_transfer_receiver: errors");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("tb_sar_transfer_receiver: errors");
        $finish;
    end

endmodule
